// ===== hw/rtl/nmea_lse_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_lse_pkg
// Shared types and character constants for the NMEA sentence extractor.
// ----------------------------------------------------------------------------
package nmea_lse_pkg;

   localparam int LEN_W  = 6;
   localparam int CHAR_W = 7;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   localparam logic [CHAR_W-1:0] CH_DOLLAR = 7'h24;
   localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_DOT    = 7'h2E;

   localparam logic [7:0] PRINT_LO = 8'd32;
   localparam logic [7:0] PRINT_HI = 8'd126;

   typedef struct packed {
      logic       req_type;
      logic [7:0] stream_byte;
   } nmea_lse_req_type;

   typedef struct packed {
      logic              found;
      logic [CHAR_W-1:0] sentence_char;
      logic [LEN_W-1:0]  sentence_length;
      logic              last_char;
   } nmea_lse_rsp_type;

   // keep CR, LF and printable codes, map the rest to a dot
   function automatic logic [CHAR_W-1:0] clean_char(input logic [7:0] b);
      logic keep;
      keep = (b == {1'b0, CH_CR}) || (b == {1'b0, CH_LF}) ||
             ((b >= PRINT_LO) && (b <= PRINT_HI));
      return keep ? b[CHAR_W-1:0] : CH_DOT;
   endfunction

endpackage

// ===== hw/rtl/nmea_lse_ram.sv =====
// ----------------------------------------------------------------------------
// nmea_lse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nmea_lse_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 191
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/nmea_latest_sentence_extractor.sv =====
// ----------------------------------------------------------------------------
// nmea_latest_sentence_extractor
// Character window for a serial receiver that hands out the newest NMEA
// sentence on request.
// ----------------------------------------------------------------------------
// Usage: items enter on req_ (valid/stall). A push item (req_type 0) stores one
// received byte in the window memory; req_stall stays low.
// A poll item (req_type 1) raises req_stall while the block scans the window:
// one memory read per held character. Each sentence character then costs a
// read and a load of the output register; a poll with no complete sentence
// gives one result with found low. The single memory port bounds both the
// scan and the readout. Results leave on rsp_ (valid/stall) from an output
// register; when rsp_stall is high that register holds and the readout waits,
// and the block takes new items once the final result of a poll is loaded,
// even while it still waits. Reset is synchronous: the window is emptied
// (start and fill count cleared) and no result is pending. Memory contents
// are not cleared.
// ----------------------------------------------------------------------------
module nmea_latest_sentence_extractor #(
   parameter int WINDOW_DEPTH = 191,
   parameter int SENTENCE_MAX = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  nmea_lse_pkg::nmea_lse_req_type req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output nmea_lse_pkg::nmea_lse_rsp_type rsp_payload
);
   import nmea_lse_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int PW = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SCAN      = 5'b00010,
      ST_NONE      = 5'b00100,
      ST_EMIT_RD   = 5'b01000,
      ST_EMIT_DATA = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [PW-1:0] pos);
      logic [PW:0] sum;
      sum = {{(PW + 1 - AW){1'b0}}, base} + {1'b0, pos};
      if (sum >= (PW + 1)'(WINDOW_DEPTH)) begin
         sum = sum - (PW + 1)'(WINDOW_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] start_ff, start_in;
   logic [PW-1:0] fill_ff, fill_in;

   logic [PW-1:0] issue_pos_ff, issue_pos_in;
   logic          data_vld_ff, data_vld_in;
   logic [PW-1:0] data_pos_ff, data_pos_in;
   logic [PW-1:0] dollar_pos_ff, dollar_pos_in;
   logic          have_dollar_ff, have_dollar_in;
   logic          lf_since_ff, lf_since_in;
   logic [PW-1:0] noncr_pos_ff, noncr_pos_in;
   logic          found_ff, found_in;
   logic [PW-1:0] sent_start_ff, sent_start_in;
   logic [PW-1:0] sent_end_ff, sent_end_in;
   logic [LEN_W-1:0] sent_len_ff, sent_len_in;
   logic [LEN_W-1:0] char_idx_ff, char_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   nmea_lse_rsp_type rsp_data_ff, rsp_data_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CHAR_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CHAR_W-1:0] ram_rd_data;

   logic          req_take;
   logic          out_free;
   logic [PW-1:0] span_len;
   logic [PW-1:0] consumed;
   logic          last_emit;

   nmea_lse_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // stored length from the '$' through the last character that is neither CR nor LF
   assign span_len  = noncr_pos_ff - dollar_pos_ff + PW'(1);
   assign consumed  = sent_end_ff + PW'(1);
   assign last_emit = (char_idx_ff + LEN_W'(1)) == sent_len_ff;

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      fill_in        = fill_ff;
      issue_pos_in   = issue_pos_ff;
      data_vld_in    = 1'b0;
      data_pos_in    = issue_pos_ff;
      dollar_pos_in  = dollar_pos_ff;
      have_dollar_in = have_dollar_ff;
      lf_since_in    = lf_since_ff;
      noncr_pos_in   = noncr_pos_ff;
      found_in       = found_ff;
      sent_start_in  = sent_start_ff;
      sent_end_in    = sent_end_ff;
      sent_len_in    = sent_len_ff;
      char_idx_in    = char_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = slot_of(start_ff, fill_ff);
      ram_wr_data    = clean_char(req_payload.stream_byte);
      ram_rd_en      = 1'b0;
      ram_rd_addr    = slot_of(start_ff, issue_pos_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_payload.req_type == REQ_PUSH) begin
                  ram_wr_en = 1'b1;
                  if (fill_ff < PW'(WINDOW_DEPTH)) begin
                     fill_in = fill_ff + PW'(1);
                  end else begin
                     // full window: overwrite the oldest character
                     ram_wr_addr = start_ff;
                     start_in    = slot_of(start_ff, PW'(1));
                  end
               end else begin
                  state_in       = ST_SCAN;
                  issue_pos_in   = '0;
                  have_dollar_in = 1'b0;
                  lf_since_in    = 1'b0;
                  found_in       = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue_pos_ff < fill_ff) begin
               ram_rd_en    = 1'b1;
               issue_pos_in = issue_pos_ff + PW'(1);
               data_vld_in  = 1'b1;
            end
            if (data_vld_ff) begin
               if (ram_rd_data == CH_DOLLAR) begin
                  dollar_pos_in  = data_pos_ff;
                  noncr_pos_in   = data_pos_ff;
                  have_dollar_in = 1'b1;
                  lf_since_in    = 1'b0;
               end else if (ram_rd_data == CH_LF) begin
                  // first LF after the newest '$' closes a candidate sentence
                  if (have_dollar_ff && !lf_since_ff) begin
                     found_in      = 1'b1;
                     sent_start_in = dollar_pos_ff;
                     sent_end_in   = data_pos_ff;
                     if (int'(span_len) > SENTENCE_MAX) begin
                        sent_len_in = LEN_W'(SENTENCE_MAX);
                     end else begin
                        sent_len_in = LEN_W'(span_len);
                     end
                  end
                  lf_since_in = 1'b1;
               end else if (ram_rd_data != CH_CR) begin
                  noncr_pos_in = data_pos_ff;
               end
            end else if (issue_pos_ff == fill_ff) begin
               char_idx_in = '0;
               state_in    = found_ff ? ST_EMIT_RD : ST_NONE;
            end
         end
         ST_NONE: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.found           = 1'b0;
               rsp_data_in.sentence_char   = '0;
               rsp_data_in.sentence_length = '0;
               rsp_data_in.last_char       = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = slot_of(start_ff, sent_start_ff + PW'(char_idx_ff));
            state_in    = ST_EMIT_DATA;
         end
         ST_EMIT_DATA: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.found           = 1'b1;
               rsp_data_in.sentence_char   = ram_rd_data;
               rsp_data_in.sentence_length = sent_len_ff;
               rsp_data_in.last_char       = last_emit;
               char_idx_in                 = char_idx_ff + LEN_W'(1);
               if (last_emit) begin
                  // drop everything through the terminating LF
                  start_in = slot_of(start_ff, consumed);
                  fill_in  = fill_ff - consumed;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         fill_ff      <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_pos_ff   <= issue_pos_in;
      data_pos_ff    <= data_pos_in;
      dollar_pos_ff  <= dollar_pos_in;
      have_dollar_ff <= have_dollar_in;
      lf_since_ff    <= lf_since_in;
      noncr_pos_ff   <= noncr_pos_in;
      found_ff       <= found_in;
      sent_start_ff  <= sent_start_in;
      sent_end_ff    <= sent_end_in;
      sent_len_ff    <= sent_len_in;
      char_idx_ff    <= char_idx_in;
      rsp_data_ff    <= rsp_data_in;
   end

endmodule

// ===== hw/rtl/nmea_lse_checker.sv =====
// ----------------------------------------------------------------------------
// nmea_lse_checker
// Port-level checks for the NMEA sentence extractor, bound to the top level.
// ----------------------------------------------------------------------------
module nmea_lse_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input nmea_lse_pkg::nmea_lse_req_type req_payload,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input nmea_lse_pkg::nmea_lse_rsp_type rsp_payload
);
   import nmea_lse_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // a miss is a single fixed item
   a_miss_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |->
         rsp_payload.last_char && (rsp_payload.sentence_length == '0) &&
         (rsp_payload.sentence_char == '0))
      else $error("malformed no-sentence result");

   // a found sentence always holds at least the '$'
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.found |-> rsp_payload.sentence_length != '0)
      else $error("found sentence with zero length");

   // pushes never block the next item, polls always do
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.req_type == REQ_PUSH) |=> !req_stall)
      else $error("stall after push");

   a_poll_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.req_type == REQ_POLL) |=> req_stall)
      else $error("no stall after poll");

endmodule

bind nmea_latest_sentence_extractor nmea_lse_checker u_nmea_lse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_payload(req_payload),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);
